/* rtl/psk_pkg.sv */
// Shared types, constants and lookup functions for the key signature pitch speller.
`default_nettype none
package psk_pkg;

	localparam int NumLetters      = 7;
	localparam int OctaveSemitones = 12;

	// Alteration codes, two bit two's complement.
	localparam logic [1:0] AccNatural = 2'b00;
	localparam logic [1:0] AccSharp   = 2'b01;
	localparam logic [1:0] AccFlat    = 2'b11;

	// Pitch class of each unaltered letter, C through B.
	localparam logic [3:0] LetterPc [NumLetters] = '{
		4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11
	};

	// Place of each letter in the order in which sharps are added (F C G D A E B).
	localparam logic [2:0] SharpPos [NumLetters] = '{
		3'd1, 3'd3, 3'd5, 3'd0, 3'd2, 3'd4, 3'd6
	};

	// Place of each letter in the order in which flats are added (B E A D G C F).
	localparam logic [2:0] FlatPos [NumLetters] = '{
		3'd5, 3'd3, 3'd1, 3'd6, 3'd4, 3'd2, 3'd0
	};

	typedef logic [2:0] letter_t;
	typedef logic [3:0] pc_t;

	// What the key signature puts on each letter.
	typedef struct packed {
		logic [NumLetters-1:0] sharp_mask;
		logic [NumLetters-1:0] flat_mask;
		logic                  sharp_key;
	} key_map_t;

	// One spelled note.
	typedef struct packed {
		letter_t     letter;
		logic [1:0]  accidental;
		logic [4:0]  octave_number;
		logic        in_key;
	} spell_t;

	// Letter that names a pitch class: the letter itself for a white key,
	// the letter a semitone below for a black key.
	function automatic letter_t pc_letter(input pc_t pc);
		letter_t l;
		case (pc)
			4'd0, 4'd1:  l = 3'd0;
			4'd2, 4'd3:  l = 3'd1;
			4'd4:        l = 3'd2;
			4'd5, 4'd6:  l = 3'd3;
			4'd7, 4'd8:  l = 3'd4;
			4'd9, 4'd10: l = 3'd5;
			4'd11:       l = 3'd6;
			default:     l = 3'd0;
		endcase
		return l;
	endfunction

	// True when the pitch class is that of an unaltered letter.
	function automatic logic pc_is_natural(input pc_t pc);
		logic n;
		case (pc)
			4'd1, 4'd3, 4'd6, 4'd8, 4'd10: n = 1'b0;
			default:                       n = 1'b1;
		endcase
		return n;
	endfunction

endpackage
`default_nettype wire

/* rtl/pitch_spelling_in_key.sv */
// Top level of the key signature pitch speller: registers, handshake and key register.
//
//  Channel   Direction  Handshake                  Payload
//  note      in         note_valid / note_ready    note_number
//  spell     out        spell_valid / spell_ready  letter, accidental, octave_number, in_key
//  key       config     key_we                     key_accidentals
//
// A request is registered on acceptance, spelled in the next cycle by the
// speller logic and held in the result register; one note per cycle is
// sustained while the result is taken. Reset clears the key to C major and
// empties both stages. A stalled result holds its register while the input
// stage still takes one more request; ready then drops until the result is taken.
`default_nettype none
module pitch_spelling_in_key (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       key_we,
	input  wire logic [3:0] key_accidentals,
	input  wire logic       note_valid,
	output logic            note_ready,
	input  wire logic [6:0] note_number,
	output logic            spell_valid,
	input  wire logic       spell_ready,
	output logic [2:0]      letter,
	output logic [1:0]      accidental,
	output logic [4:0]      octave_number,
	output logic            in_key
);

	logic              [3:0] key_q;
	logic                    valid_s1;
	logic              [6:0] note_s1;
	logic                    valid_s2;
	psk_pkg::spell_t         spell_s2;
	psk_pkg::key_map_t       key_map;
	psk_pkg::spell_t         spell;
	logic                    load_s2;
	logic                    load_s1;

	// Stage control: each stage moves when the one after it has room.
	always_comb begin
		load_s2    = valid_s1 && (!valid_s2 || spell_ready);
		note_ready = !valid_s1 || load_s2;
		load_s1    = note_valid && note_ready;
	end

	// Key register and stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q    <= 4'd0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (key_we) begin
				key_q <= key_accidentals;
			end
			if (note_ready) begin
				valid_s1 <= note_valid;
			end
			if (!valid_s2 || spell_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (load_s1) begin
			note_s1 <= note_number;
		end
		if (load_s2) begin
			spell_s2 <= spell;
		end
	end

	psk_key_map u_key_map (
		.key_accidentals (key_q),
		.key_map         (key_map)
	);

	psk_speller u_speller (
		.note_number (note_s1),
		.key_map     (key_map),
		.spell       (spell)
	);

	// Result outputs.
	always_comb begin
		spell_valid   = valid_s2;
		letter        = spell_s2.letter;
		accidental    = spell_s2.accidental;
		octave_number = spell_s2.octave_number;
		in_key        = spell_s2.in_key;
	end

`ifndef ASSERT_OFF
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		load_s1 |=> valid_s1)
		else $error("accepted request did not reach the input stage");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !load_s2) |=> (valid_s1 && $stable(note_s1)))
		else $error("blocked input stage lost its note");

	a_acc_code: assert property (@(posedge clk) disable iff (!arst_n)
		spell_valid |-> (accidental != 2'b10))
		else $error("accidental outside flat, natural, sharp");

	a_letter_range: assert property (@(posedge clk) disable iff (!arst_n)
		spell_valid |-> (letter <= 3'd6))
		else $error("letter index out of range");

	a_octave_range: assert property (@(posedge clk) disable iff (!arst_n)
		spell_valid |-> ($signed(octave_number) >= -5'sd2 && $signed(octave_number) <= 5'sd9))
		else $error("octave number out of range");
`endif

endmodule
`default_nettype wire

/* rtl/psk_key_map.sv */
// Decodes the key signature register into per-letter sharp and flat masks.
`default_nettype none
module psk_key_map (
	input  wire logic [3:0]       key_accidentals,
	output psk_pkg::key_map_t     key_map
);

	logic       key_neg;
	logic       key_valid;
	logic [2:0] key_mag;

	// A zero or positive signature counts as a sharp key; the minus eight
	// pattern alters nothing but still ranks as a flat key.
	always_comb begin
		key_neg   = key_accidentals[3];
		key_valid = (key_accidentals != 4'b1000);
		key_mag   = key_neg ? (3'd0 - key_accidentals[2:0]) : key_accidentals[2:0];
	end

	// Each letter is altered when its place in the order is below the count.
	always_comb begin
		key_map.sharp_key = !key_neg;
		for (int s = 0; s < psk_pkg::NumLetters; s++) begin
			key_map.sharp_mask[s] = !key_neg && (psk_pkg::SharpPos[s] < key_mag);
			key_map.flat_mask[s]  = key_neg && key_valid &&
				(psk_pkg::FlatPos[s] < key_mag);
		end
	end

endmodule
`default_nettype wire

/* rtl/psk_speller.sv */
// Spells one note number under the decoded key signature.
`default_nettype none
module psk_speller (
	input  wire logic [6:0]        note_number,
	input  wire psk_pkg::key_map_t key_map,
	output psk_pkg::spell_t        spell
);

	logic [12:0]                   prod;
	logic [3:0]                    q_est;
	logic [7:0]                    r_ext;
	logic [3:0]                    oct_q;
	psk_pkg::pc_t                  pc;
	logic [psk_pkg::NumLetters-1:0] match;
	psk_pkg::pc_t                  tgt;
	psk_pkg::letter_t              key_letter;
	logic [1:0]                    key_acc;
	logic                          found;
	psk_pkg::letter_t              base_letter;
	psk_pkg::letter_t              out_letter;
	logic [1:0]                    out_acc;
	logic [4:0]                    adj;

	// Split the note into octave and pitch class: reciprocal multiply by
	// 43/512, then one compare and subtract to correct the estimate.
	always_comb begin
		prod  = {6'd0, note_number} * 13'd43;
		q_est = prod[12:9];
		r_ext = {1'b0, note_number} - 8'({4'd0, q_est} * 8'd12);
		if (r_ext >= 8'(psk_pkg::OctaveSemitones)) begin
			oct_q = q_est + 4'd1;
			pc    = 4'(r_ext - 8'(psk_pkg::OctaveSemitones));
		end else begin
			oct_q = q_est;
			pc    = r_ext[3:0];
		end
	end

	// Compare each letter with its key alteration against the pitch class.
	always_comb begin
		for (int s = 0; s < psk_pkg::NumLetters; s++) begin
			if (key_map.sharp_mask[s]) begin
				tgt = (psk_pkg::LetterPc[s] == 4'd11) ? 4'd0 : psk_pkg::LetterPc[s] + 4'd1;
			end else if (key_map.flat_mask[s]) begin
				tgt = (psk_pkg::LetterPc[s] == 4'd0) ? 4'd11 : psk_pkg::LetterPc[s] - 4'd1;
			end else begin
				tgt = psk_pkg::LetterPc[s];
			end
			match[s] = (tgt == pc);
		end
	end

	// The lowest matching letter wins.
	always_comb begin
		key_letter = 3'd0;
		key_acc    = psk_pkg::AccNatural;
		for (int s = psk_pkg::NumLetters - 1; s >= 0; s--) begin
			if (match[s]) begin
				key_letter = 3'(s);
				if (key_map.sharp_mask[s]) begin
					key_acc = psk_pkg::AccSharp;
				end else if (key_map.flat_mask[s]) begin
					key_acc = psk_pkg::AccFlat;
				end else begin
					key_acc = psk_pkg::AccNatural;
				end
			end
		end
		found = |match;
	end

	// Outside the key a white key stays natural; a black key is spelled
	// as a sharp in a sharp key and as a flat otherwise.
	always_comb begin
		base_letter = psk_pkg::pc_letter(pc);
		if (found) begin
			out_letter = key_letter;
			out_acc    = key_acc;
		end else if (psk_pkg::pc_is_natural(pc)) begin
			out_letter = base_letter;
			out_acc    = psk_pkg::AccNatural;
		end else if (key_map.sharp_key) begin
			out_letter = base_letter;
			out_acc    = psk_pkg::AccSharp;
		end else begin
			out_letter = base_letter + 3'd1;
			out_acc    = psk_pkg::AccFlat;
		end
	end

	// The octave follows the unaltered letter, which can cross a C boundary.
	always_comb begin
		if (out_acc == psk_pkg::AccSharp && pc == 4'd0) begin
			adj = 5'h1F;
		end else if (out_acc == psk_pkg::AccFlat && pc == 4'd11) begin
			adj = 5'd1;
		end else begin
			adj = 5'd0;
		end
		spell.letter        = out_letter;
		spell.accidental    = out_acc;
		spell.octave_number = {1'b0, oct_q} - 5'd1 + adj;
		spell.in_key        = found;
	end

endmodule
`default_nettype wire
